// ===== rtl/core/smti_pkg.sv =====
package smti_pkg;

  localparam logic [2:0] MAX_RES   = 3'd6;
  localparam logic [2:0] RES_RESET = 3'd3;

  localparam logic [1:0] REGION_NONE   = 2'd0;
  localparam logic [1:0] REGION_TOP    = 2'd1;
  localparam logic [1:0] REGION_BAND   = 2'd2;
  localparam logic [1:0] REGION_BOTTOM = 2'd3;

  typedef struct packed {
    logic [1:0]  region;
    logic [14:0] base;
    logic [8:0]  cols;
    logic [7:0]  j;
    logic [7:0]  n;
    logic        odd;
    logic        last;
  } smti_loc_t;

endpackage

// ===== rtl/core/smti_req_if.sv =====
interface smti_req_if;
  logic        valid;
  logic        ready;
  logic [15:0] triangle_number;

  modport source (output valid, output triangle_number, input ready);
  modport sink (input valid, input triangle_number, output ready);
endinterface

// ===== rtl/core/smti_rsp_if.sv =====
interface smti_rsp_if;
  logic        valid;
  logic        ready;
  logic [14:0] first_index;
  logic [14:0] second_index;
  logic [14:0] third_index;
  logic        in_range;
  logic        is_last;

  modport source (
    output valid, output first_index, output second_index, output third_index,
    output in_range, output is_last, input ready
  );
  modport sink (
    input valid, input first_index, input second_index, input third_index,
    input in_range, input is_last, output ready
  );
endinterface

// ===== rtl/core/sphere_mesh_triangle_indexer.sv =====
// Sphere mesh triangle indexer: maps a triangle number of a latitude-longitude
// sphere mesh to its three vertex indices.
// Channels: req carries triangle_number in; rsp carries first_index,
// second_index, third_index, in_range and is_last out, both valid/ready.
// cfg_we/cfg_wdata write the resolution register (columns = 4 << resolution);
// values above 6 act as 6. Write it only while no request is in flight.
// A request accepted into the input register passes on to the result register
// and from there shows on rsp (input register, then result register).
// Throughput: one triangle per cycle while rsp does not stall, set by the
// single pass of shifts, adds and compares between the registers.
// Numbers at or past the triangle count give in_range 0 and zero indices.
// Reset clears both stage valids and sets resolution to 3.
// When rsp stalls the result register holds; the input register still takes
// a request while the result register is empty or being taken, so req.ready
// drops only with both stages full and rsp stalled.
module sphere_mesh_triangle_indexer (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_wdata,
  smti_req_if.sink    req,
  smti_rsp_if.source  rsp
);
  import smti_pkg::*;

  logic        v1;
  logic        v2;
  logic [2:0]  resolution;
  logic [15:0] t1;
  logic [2:0]  r1;
  logic        adv2;
  smti_loc_t   loc;
  logic [14:0] a_next;
  logic [14:0] b_next;
  logic [14:0] c_next;
  logic [14:0] a2;
  logic [14:0] b2;
  logic [14:0] c2;
  logic        ok2;
  logic        last2;

  assign adv2      = !v2 || rsp.ready;
  assign req.ready = !v1 || adv2;

  smti_locate u_locate (
    .triangle_number (t1),
    .resolution      (r1),
    .loc             (loc)
  );

  smti_index u_index (
    .loc          (loc),
    .first_index  (a_next),
    .second_index (b_next),
    .third_index  (c_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1         <= 1'b0;
      v2         <= 1'b0;
      resolution <= RES_RESET;
    end else begin
      if (cfg_we) begin
        resolution <= cfg_wdata;
      end
      if (req.ready) begin
        v1 <= req.valid;
      end
      if (adv2) begin
        v2 <= v1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      t1 <= req.triangle_number;
      r1 <= resolution;
    end
    if (adv2 && v1) begin
      a2    <= a_next;
      b2    <= b_next;
      c2    <= c_next;
      ok2   <= (loc.region != REGION_NONE);
      last2 <= loc.last;
    end
  end

  assign rsp.valid        = v2;
  assign rsp.first_index  = a2;
  assign rsp.second_index = b2;
  assign rsp.third_index  = c2;
  assign rsp.in_range     = ok2;
  assign rsp.is_last      = last2;

  a_reset_clears: assert property (@(posedge clk) rst |=> !v1 && !v2)
    else $error("pipeline valid after reset");

  a_stall_only: assert property (@(posedge clk) disable iff (rst)
    !req.ready |-> (v1 && v2 && !rsp.ready))
    else $error("request refused without output stall");

  a_zero_out: assert property (@(posedge clk) disable iff (rst)
    (v2 && !ok2) |-> (a2 == 15'd0 && b2 == 15'd0 && c2 == 15'd0 && !last2))
    else $error("out-of-range result carries indices");

  a_last_in_range: assert property (@(posedge clk) disable iff (rst)
    (v2 && last2) |-> ok2)
    else $error("last flag on out-of-range result");
endmodule

// ===== rtl/core/smti_locate.sv =====
module smti_locate (
  input  logic [15:0]      triangle_number,
  input  logic [2:0]       resolution,
  output smti_pkg::smti_loc_t loc
);
  import smti_pkg::*;

  always_comb begin
    logic [2:0]  r;
    logic [3:0]  r2;
    logic [8:0]  cols;
    logic [8:0]  cmask;
    logic [16:0] count;
    logic [16:0] band_tris;
    logic [16:0] t17;
    logic [16:0] u;
    logic [16:0] band_pos;
    logic [16:0] band_sh;
    logic [16:0] k;
    logic [14:0] band_base;
    logic [14:0] bot_base;
    logic [7:0]  jx;
    logic [8:0]  nx;

    r         = (resolution > MAX_RES) ? MAX_RES : resolution;
    r2        = {r, 1'b0};
    cols      = 9'd4 << r;
    cmask     = cols - 9'd1;
    count     = (17'd16 << r2) - (17'd8 << r);
    band_tris = (17'd16 << r2) - (17'd16 << r);
    t17       = {1'b0, triangle_number};
    u         = t17 - {8'd0, cols};
    band_pos  = u & ((17'd8 << r) - 17'd1);
    band_sh   = u >> ({1'b0, r} + 4'd3);
    k         = u - band_tris;
    band_base = 15'd1 + ({8'd0, band_sh[6:0]} << ({1'b0, r} + 4'd2));
    bot_base  = 15'd1 + band_tris[15:1];

    loc.cols = cols;
    loc.odd  = 1'b0;
    loc.last = (t17 == (count - 17'd1));
    jx       = 8'd0;
    loc.base = 15'd1;

    if (t17 >= count) begin
      loc.region = REGION_NONE;
      loc.last   = 1'b0;
    end else if (t17 < {8'd0, cols}) begin
      loc.region = REGION_TOP;
      jx         = triangle_number[7:0];
    end else if (u < band_tris) begin
      loc.region = REGION_BAND;
      jx         = band_pos[8:1];
      loc.odd    = band_pos[0];
      loc.base   = band_base;
    end else begin
      loc.region = REGION_BOTTOM;
      jx         = k[7:0];
      loc.base   = bot_base;
    end

    nx    = ({1'b0, jx} + 9'd1) & cmask;
    loc.j = jx;
    loc.n = nx[7:0];
  end
endmodule

// ===== rtl/core/smti_index.sv =====
module smti_index (
  input  smti_pkg::smti_loc_t loc,
  output logic [14:0]         first_index,
  output logic [14:0]         second_index,
  output logic [14:0]         third_index
);
  import smti_pkg::*;

  logic [14:0] j15;
  logic [14:0] n15;
  logic [14:0] bot;

  assign j15 = {7'd0, loc.j};
  assign n15 = {7'd0, loc.n};
  assign bot = loc.base + {6'd0, loc.cols};

  always_comb begin
    unique case (loc.region)
      REGION_TOP: begin
        first_index  = 15'd0;
        second_index = loc.base + n15;
        third_index  = loc.base + j15;
      end
      REGION_BAND: begin
        first_index = loc.base + j15;
        if (loc.odd) begin
          second_index = loc.base + n15;
          third_index  = bot + n15;
        end else begin
          second_index = bot + n15;
          third_index  = bot + j15;
        end
      end
      REGION_BOTTOM: begin
        first_index  = loc.base + j15;
        second_index = loc.base + n15;
        third_index  = bot;
      end
      default: begin
        first_index  = 15'd0;
        second_index = 15'd0;
        third_index  = 15'd0;
      end
    endcase
  end
endmodule
